>>> rtl/slpt_pkg.sv
// Package for the spinning lidar point timestamper.
// Shared types, constants and the CORDIC angle table. No dependencies.
`default_nettype none
package slpt_pkg;
   localparam int MaxRingsDefault   = 32;
   localparam int CordicStepsDefault = 16;
   localparam int TabLen = 24;
   localparam int ReqDataW = 96;
   localparam int RspDataW = 96;
   localparam int TimeW = 24;
   localparam logic [23:0] TimeMax = 24'hFFFFFF;
   localparam logic [16:0] FullTurnQ8 = 17'd92160;
   localparam logic [16:0] RevUs = 17'd99723;
   localparam logic [47:0] HalfTurnQ16 = 48'd11796480;

   typedef enum logic [1:0] {
      CSR_RING_COUNT = 2'd0,
      CSR_KEEP_EVERY = 2'd1,
      CSR_TIME_SCALE = 2'd2,
      CSR_MIN_RANGE  = 2'd3
   } csr_index_type;

   // front-to-back queue entry
   typedef struct packed {
      logic signed [18:0] x;
      logic signed [18:0] y;
      logic signed [18:0] z;
      logic [7:0]         reflect;
      logic [6:0]         ring;
      logic [19:0]        raw;
      logic               given;
      logic               take;
      logic               frame_start;
   } item_type;

   function automatic logic [47:0] atan_entry(input logic [4:0] i);
      logic [47:0] v;
      case (i)
         5'd0: v = 48'd2949120;  5'd1: v = 48'd1740967;  5'd2: v = 48'd919879;
         5'd3: v = 48'd466945;   5'd4: v = 48'd234379;   5'd5: v = 48'd117304;
         5'd6: v = 48'd58666;    5'd7: v = 48'd29335;    5'd8: v = 48'd14668;
         5'd9: v = 48'd7334;     5'd10: v = 48'd3667;    5'd11: v = 48'd1833;
         5'd12: v = 48'd917;     5'd13: v = 48'd458;     5'd14: v = 48'd229;
         5'd15: v = 48'd115;     5'd16: v = 48'd57;      5'd17: v = 48'd29;
         5'd18: v = 48'd14;      5'd19: v = 48'd7;       5'd20: v = 48'd4;
         5'd21: v = 48'd2;       5'd22: v = 48'd1;
         default: v = 48'd0;
      endcase
      return v;
   endfunction
endpackage
`default_nettype wire

>>> rtl/slpt_front.sv
// Front end: accepts points, advances the frame index phase, tags frame start.
// Depends on slpt_pkg.
`default_nettype none
module slpt_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [7:0]         keep_every,
   input  wire logic               in_fire,
   input  wire logic [slpt_pkg::ReqDataW-1:0] in_data,
   input  wire logic               in_start,
   input  wire logic               in_given,
   output slpt_pkg::item_type      item
);
   logic [7:0] phase_ff, phase_in, cur, keep;
   always_comb begin
      keep = (keep_every == 8'd0) ? 8'd1 : keep_every;
      cur = in_start ? 8'd0 : phase_ff;
      phase_in = phase_ff;
      if (in_fire)
         phase_in = ({1'b0, cur} + 9'd1 >= {1'b0, keep}) ? 8'd0 : cur + 8'd1;
      item.x = in_data[18:0];
      item.y = in_data[37:19];
      item.z = in_data[56:38];
      item.reflect = in_data[64:57];
      item.ring = in_data[71:65];
      item.raw = in_data[91:72];
      item.given = in_given;
      item.take = (cur == 8'd0);
      item.frame_start = in_start;
   end
   always_ff @(posedge clock) begin
      if (reset) phase_ff <= 8'd0;
      else       phase_ff <= phase_in;
   end
endmodule
`default_nettype wire

>>> rtl/slpt_back.sv
// Back end: range check, iterative CORDIC yaw, per-ring time update.
// Depends on slpt_pkg.
`default_nettype none
module slpt_back #(
   parameter int MAX_RINGS = slpt_pkg::MaxRingsDefault,
   parameter int CORDIC_STEPS = slpt_pkg::CordicStepsDefault
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [7:0]         ring_count,
   input  wire logic [15:0]        time_scale_q8,
   input  wire logic [15:0]        min_range_mm,
   input  wire logic               q_valid,
   output logic                    q_ready,
   input  wire slpt_pkg::item_type q_item,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output logic [slpt_pkg::RspDataW-1:0] out_data
);
   localparam int RW = (MAX_RINGS > 1) ? $clog2(MAX_RINGS) : 1;
   localparam int NS = (CORDIC_STEPS > slpt_pkg::TabLen) ? slpt_pkg::TabLen : CORDIC_STEPS;
   // ceil(2^35 / 361): exact floor division by 361 for dividends below 2^27
   localparam logic [26:0] Recip361 = 27'd95179331;

   typedef enum logic [2:0] {
      S_IDLE, S_SQ, S_SUM, S_CORD, S_DIV, S_UPD, S_OUT
   } state_type;

   state_type state_ff;
   slpt_pkg::item_type it_ff;
   logic [37:0] sq_ff [3];
   logic [39:0] r2_ff;
   logic [31:0] thr_ff;
   logic signed [47:0] cx_ff, cy_ff, cz_ff;
   logic [4:0] step_ff;
   logic [23:0] t_ff;
   logic [RW-1:0] ring_ff;
   logic seen_ff [MAX_RINGS];
   logic signed [16:0] fyaw_ff [MAX_RINGS];
   logic [23:0] ltime_ff [MAX_RINGS];
   logic signed [16:0] yaw_ff;
   logic [35:0] prod_ff;
   logic out_valid_ff;
   logic [slpt_pkg::RspDataW-1:0] out_data_ff;

   logic ring_ok;
   logic signed [47:0] zr, dxs, dys;
   logic signed [16:0] yaw_c;
   logic signed [18:0] dd;
   logic [17:0] d_u;
   logic [24:0] tsum;
   logic [23:0] tnew;
   logic [53:0] quo;
   logic load_out;

   always_comb begin
      ring_ok = ({1'b0, q_item.ring} < ring_count) && (32'(q_item.ring) < MAX_RINGS);
      dxs = cy_ff >>> step_ff;
      dys = cx_ff >>> step_ff;
      zr = cz_ff + 48'sd128;
      yaw_c = 17'(zr >>> 8);
      dd = 19'(fyaw_ff[ring_ff]) - 19'(yaw_ff);
      if (yaw_ff > fyaw_ff[ring_ff]) dd = dd + 19'(slpt_pkg::FullTurnQ8);
      d_u = dd[18] ? 18'd0 : dd[17:0];
      // (d*3125/8) / 361 by reciprocal multiplication
      quo = 54'(prod_ff[29:3]) * 54'(Recip361);
      tsum = {1'b0, t_ff};
      if (t_ff < ltime_ff[ring_ff]) tsum = tsum + 25'(slpt_pkg::RevUs);
      tnew = tsum[24] ? slpt_pkg::TimeMax : tsum[23:0];
      load_out = (state_ff == S_OUT) && it_ff.take && (!out_valid_ff || out_ready);
   end

   assign q_ready = (state_ff == S_IDLE);
   assign out_valid = out_valid_ff;
   assign out_data = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_RINGS; i++) seen_ff[i] <= 1'b0;
      end else begin
         if (load_out) out_valid_ff <= 1'b1;
         else if (out_ready) out_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (q_valid) begin
               it_ff <= q_item;
               ring_ff <= RW'(q_item.ring);
               if (q_item.frame_start)
                  for (int i = 0; i < MAX_RINGS; i++) seen_ff[i] <= 1'b0;
               if (ring_ok) state_ff <= S_SQ;
            end
            S_SQ: begin
               sq_ff[0] <= 38'(it_ff.x * it_ff.x);
               sq_ff[1] <= 38'(it_ff.y * it_ff.y);
               sq_ff[2] <= 38'(it_ff.z * it_ff.z);
               thr_ff <= 32'(min_range_mm) * 32'(min_range_mm);
               prod_ff <= 36'(it_ff.raw) * 36'(time_scale_q8);
               state_ff <= S_SUM;
            end
            S_SUM: begin
               r2_ff <= 40'(sq_ff[0]) + 40'(sq_ff[1]) + 40'(sq_ff[2]);
               step_ff <= 5'd0;
               if (it_ff.x < 0) begin
                  cx_ff <= -(48'(it_ff.x) <<< 16);
                  cy_ff <= -(48'(it_ff.y) <<< 16);
                  cz_ff <= (it_ff.y >= 0) ? $signed(slpt_pkg::HalfTurnQ16)
                                          : -$signed(slpt_pkg::HalfTurnQ16);
               end else begin
                  cx_ff <= 48'(it_ff.x) <<< 16;
                  cy_ff <= 48'(it_ff.y) <<< 16;
                  cz_ff <= 48'sd0;
               end
               state_ff <= S_CORD;
            end
            S_CORD: begin
               if (r2_ff < 40'(thr_ff)) state_ff <= S_IDLE;
               else if (it_ff.given) begin
                  t_ff <= (|prod_ff[35:32]) ? slpt_pkg::TimeMax : prod_ff[31:8];
                  state_ff <= S_OUT;
               end else if (step_ff == 5'(NS)) begin
                  yaw_ff <= yaw_c;
                  state_ff <= S_DIV;
               end else begin
                  if (cy_ff > 0) begin
                     cx_ff <= cx_ff + dxs; cy_ff <= cy_ff - dys;
                     cz_ff <= cz_ff + $signed(slpt_pkg::atan_entry(step_ff));
                  end else if (cy_ff < 0) begin
                     cx_ff <= cx_ff - dxs; cy_ff <= cy_ff + dys;
                     cz_ff <= cz_ff - $signed(slpt_pkg::atan_entry(step_ff));
                  end
                  step_ff <= step_ff + 5'd1;
               end
            end
            S_DIV: begin
               if (!seen_ff[ring_ff]) begin
                  seen_ff[ring_ff] <= 1'b1;
                  fyaw_ff[ring_ff] <= yaw_ff;
                  ltime_ff[ring_ff] <= 24'd0;
                  state_ff <= S_IDLE;
               end else begin
                  // d*100000/92416 = (d*3125/8)/361, d < 2^18 so d*3125 < 2^30
                  prod_ff <= 36'(d_u) * 36'd3125;
                  state_ff <= S_UPD;
               end
            end
            S_UPD: begin
               t_ff <= {5'd0, quo[53:35]};
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!it_ff.given) ltime_ff[ring_ff] <= tnew;
               if (!it_ff.take) state_ff <= S_IDLE;
               else if (load_out) begin
                  out_data_ff <= {7'd0, it_ff.given ? t_ff : tnew, it_ff.reflect,
                                  it_ff.z, it_ff.y, it_ff.x};
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid) else $error("result lost");
   assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> $stable(out_data)) else $error("result changed");
   assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !q_ready) else $error("ready while busy");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |=> state_ff == S_IDLE || state_ff == S_UPD)
      else $error("bad step after yaw");
endmodule
`default_nettype wire

>>> rtl/spinning_lidar_point_timestamper.sv
// Top level of the spinning lidar point timestamper.
// Depends on slpt_pkg, slpt_front and slpt_back.
// Usage:
//  req_ carries one point per transaction; tuser bit 0 times_given, bit 1 frame_start.
//  rsp_ carries kept points with their offset time; dropped points give nothing.
//  csr_ writes ring_count, keep_every, time_scale_q8, min_range_mm by index;
//   write only while no point is in flight.
// A kept point passes the queue, then the back end's idle, square, sum, CORDIC
//  and output steps; one with derived times also the divide and update steps.
// The back end holds one point at a time, set by the iterative CORDIC
//  that shares one add stage per step. It lets a point go at its idle step
//  when its ring is out of range, after the CORDIC range check when too near,
//  after the divide step for the first point of a ring, else after output.
// The front tags the frame index phase; a one-entry queue holds the tagged
//  point while the back end works, so the next point can be taken early.
// Reset clears ring seen flags, the phase and the registers to their defaults.
// A stalled rsp_ holds the result; the back end waits at its output step and
//  the queue then fills and drops req_tready.
`default_nettype none
module spinning_lidar_point_timestamper #(
   parameter int MAX_RINGS = slpt_pkg::MaxRingsDefault,
   parameter int CORDIC_STEPS = slpt_pkg::CordicStepsDefault
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // x, y, z, reflect, ring_id, raw_time_us, zero pad
   input  wire logic [slpt_pkg::ReqDataW-1:0] req_tdata,
   input  wire logic [1:0]   req_tuser,  // times_given, frame_start
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // out_x, out_y, out_z, out_reflect, out_time_us, zero pad
   output logic [slpt_pkg::RspDataW-1:0] rsp_tdata,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [15:0]  csr_data
);
   logic [7:0] ring_count_ff, keep_every_ff;
   logic [15:0] scale_ff, min_range_ff;
   slpt_pkg::item_type fitem, q_ff;
   logic q_valid_ff, q_ready, in_fire;

   assign csr_ready = 1'b1;
   // queue takes a point when empty or draining this cycle
   assign req_tready = !q_valid_ff || q_ready;
   assign in_fire = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_count_ff <= 8'd32;
         keep_every_ff <= 8'd1;
         scale_ff <= 16'd256;
         min_range_ff <= 16'd4000;
         q_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (slpt_pkg::csr_index_type'(csr_index))
               slpt_pkg::CSR_RING_COUNT: ring_count_ff <= csr_data[7:0];
               slpt_pkg::CSR_KEEP_EVERY: keep_every_ff <= csr_data[7:0];
               slpt_pkg::CSR_TIME_SCALE: scale_ff <= csr_data;
               slpt_pkg::CSR_MIN_RANGE:  min_range_ff <= csr_data;
               default: ;
            endcase
         end
         if (in_fire) q_valid_ff <= 1'b1;
         else if (q_ready) q_valid_ff <= 1'b0;
      end
      if (in_fire) q_ff <= fitem;
   end

   slpt_front u_front (
      .clock, .reset, .keep_every(keep_every_ff), .in_fire,
      .in_data(req_tdata), .in_start(req_tuser[1]), .in_given(req_tuser[0]),
      .item(fitem)
   );

   slpt_back #(.MAX_RINGS(MAX_RINGS), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
      .clock, .reset, .ring_count(ring_count_ff), .time_scale_q8(scale_ff),
      .min_range_mm(min_range_ff), .q_valid(q_valid_ff), .q_ready, .q_item(q_ff),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_data(rsp_tdata)
   );
endmodule
`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for spinning_lidar_point_timestamper.
// Drives points on req_, checks kept points on rsp_ against an in-bench predictor.
// Depends on slpt_pkg and the RTL top level.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
   localparam int NumRings = 32;
   localparam int NumSteps = 16;
   localparam int WatchLimit = 20000;
   localparam int SettleCycles = 60;

   typedef struct packed {
      logic signed [18:0] x;
      logic signed [18:0] y;
      logic signed [18:0] z;
      logic [7:0]         reflect;
      logic [6:0]         ring;
      logic [19:0]        raw;
      logic               given;
      logic               start;
   } point_type;

   // bus order: x in the lowest bits, time on top
   typedef struct packed {
      logic [23:0]        t;
      logic [7:0]         reflect;
      logic signed [18:0] z;
      logic signed [18:0] y;
      logic signed [18:0] x;
   } kept_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [95:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [15:0] csr_data = '0;

   spinning_lidar_point_timestamper dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Predictor state: a shadow of the registers and the per-ring memory.
   logic [7:0] cfg_rings, cfg_keep;
   logic [15:0] cfg_scale, cfg_minr;
   logic seen_q [NumRings];
   logic signed [16:0] first_yaw_q [NumRings];
   logic [23:0] last_time_q [NumRings];
   logic [7:0] phase_q;

   point_type pending_points[$];
   kept_type expected_points[$];
   int fail_count = 0;
   bit idle_off = 0;      // last part of the run: no random idling
   bit hold_rsp = 0;      // long receiver hold-off request
   bit drain_req = 0;     // sender pause

   function automatic longint shr_floor(longint v, int s);
      return v >>> s;
   endfunction

   // Vectoring CORDIC yaw, 1/256 degree
   function automatic int yaw_of(longint px, longint py);
      longint xa, ya, za, dx, dy;
      xa = px * 65536; ya = py * 65536; za = 0;
      if (xa < 0) begin
         za = (ya >= 0) ? 11796480 : -11796480;
         xa = -xa; ya = -ya;
      end
      for (int i = 0; i < NumSteps; i++) begin
         dx = shr_floor(ya, i); dy = shr_floor(xa, i);
         if (ya > 0) begin
            xa += dx; ya -= dy; za += longint'(slpt_pkg::atan_entry(5'(i)));
         end else if (ya < 0) begin
            xa -= dx; ya += dy; za -= longint'(slpt_pkg::atan_entry(5'(i)));
         end
      end
      return int'(shr_floor(za + 128, 8));
   endfunction

   // Append a point to the stimulus queue.
   task automatic enqueue_point(input point_type p);
      pending_points = {pending_points, p};
   endtask

   // Advance the shadow state by one accepted point; queue a kept point.
   task automatic timestamp_point(input point_type p);
      logic take;
      logic [7:0] keep;
      longint x, y, z, r2, d, t;
      int yaw;
      kept_type k;
      x = p.x; y = p.y; z = p.z;
      keep = (cfg_keep == 0) ? 8'd1 : cfg_keep;
      if (p.start) begin
         foreach (seen_q[i]) seen_q[i] = 1'b0;
         phase_q = 0;
      end
      take = (phase_q == 0);
      phase_q = (int'(phase_q) + 1 >= keep) ? 8'd0 : phase_q + 8'd1;
      if (p.ring >= cfg_rings || p.ring >= NumRings) return;
      r2 = x * x + y * y + z * z;
      if (r2 < longint'(cfg_minr) * longint'(cfg_minr)) return;
      if (p.given) begin
         t = (longint'(p.raw) * longint'(cfg_scale)) >>> 8;
      end else begin
         yaw = yaw_of(x, y);
         if (!seen_q[p.ring]) begin
            seen_q[p.ring] = 1'b1;
            first_yaw_q[p.ring] = 17'(yaw);
            last_time_q[p.ring] = 0;
            return;
         end
         d = longint'(first_yaw_q[p.ring]) - yaw;
         if (yaw > first_yaw_q[p.ring]) d += 92160;
         if (d < 0) d = 0;
         t = (d * 100000) / 92416;
         if (t < last_time_q[p.ring]) t += 99723;
         if (t > 16777215) t = 16777215;
         last_time_q[p.ring] = 24'(t);
      end
      if (t > 16777215) t = 16777215;
      if (take) begin
         k.x = p.x; k.y = p.y; k.z = p.z; k.reflect = p.reflect; k.t = 24'(t);
         expected_points = {expected_points, k};
      end
   endtask

   // Driver: offer queued points, with random gaps.
   int req_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            timestamp_point(pending_points.pop_front());
         end
         // after a transaction the popped point is gone; decide what to offer next
         if (req_tvalid && !req_tready) begin
            // hold the current point
         end else if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_points.size() > 0 && !drain_req) begin
            if (!idle_off && $urandom_range(0, 9) == 0) begin
               req_gap <= $urandom_range(1, 10) - 1;
               req_tvalid <= 1'b0;
            end else begin
               req_tvalid <= 1'b1;
               req_tdata <= {4'd0, pending_points[0].raw, pending_points[0].ring,
                             pending_points[0].reflect, pending_points[0].z,
                             pending_points[0].y, pending_points[0].x};
               req_tuser <= {pending_points[0].start, pending_points[0].given};
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Monitor: compare each kept point with the oldest expectation.
   int rsp_gap = 0;
   kept_type got, want;
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[88:0];
         if (expected_points.size() == 0) begin
            $error("unexpected point, data %h", rsp_tdata);
            fail_count++;
         end else begin
            want = expected_points.pop_front();
            if (got.x != want.x) begin
               $error("out_x expected %0d actual %0d", want.x, got.x); fail_count++;
            end
            if (got.y != want.y) begin
               $error("out_y expected %0d actual %0d", want.y, got.y); fail_count++;
            end
            if (got.z != want.z) begin
               $error("out_z expected %0d actual %0d", want.z, got.z); fail_count++;
            end
            if (got.reflect != want.reflect) begin
               $error("out_reflect expected %0d actual %0d", want.reflect, got.reflect);
               fail_count++;
            end
            if (got.t != want.t) begin
               $error("out_time_us expected %0d actual %0d", want.t, got.t); fail_count++;
            end
         end
      end
      // receiver readiness: random stall bursts, or a held-off stretch
      if (reset || hold_rsp) begin
         rsp_tready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap <= rsp_gap - 1;
         rsp_tready <= 1'b0;
      end else if (!idle_off && $urandom_range(0, 7) == 0) begin
         rsp_gap <= $urandom_range(1, 10) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog: count cycles with no transaction on any channel.
   int quiet = 0;
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || hold_rsp
          || (csr_valid && csr_ready) || reset)
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet >= WatchLimit) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic write_reg(input slpt_pkg::csr_index_type idx, input logic [15:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         slpt_pkg::CSR_RING_COUNT: cfg_rings = val[7:0];
         slpt_pkg::CSR_KEEP_EVERY: cfg_keep = val[7:0];
         slpt_pkg::CSR_TIME_SCALE: cfg_scale = val;
         default:                  cfg_minr = val;
      endcase
   endtask

   // Wait until every queued point is accepted and every kept point has arrived.
   task automatic drain_all();
      while (pending_points.size() > 0 || req_tvalid || expected_points.size() > 0)
         @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   function automatic point_type rand_point(input bit start, input bit given,
                                            input int max_ring, input bit near);
      point_type p;
      int span;
      span = near ? 6000 : 262143;
      p.x = 19'($urandom_range(0, 2 * span) - span);
      p.y = 19'($urandom_range(0, 2 * span) - span);
      p.z = 19'($urandom_range(0, 2 * span) - span);
      if ($urandom_range(0, 15) == 0) p.x = 19'($urandom);
      if ($urandom_range(0, 15) == 0) p.y = 19'($urandom);
      if ($urandom_range(0, 15) == 0) p.z = 19'($urandom);
      p.reflect = 8'($urandom);
      p.ring = 7'($urandom_range(0, max_ring));
      p.raw = 20'($urandom);
      p.given = given;
      p.start = start;
      return p;
   endfunction

   // Queue a frame of points with random ring ids up to max_ring.
   task automatic push_frame(input int npts, input bit given, input int max_ring);
      point_type p;
      for (int i = 0; i < npts; i++) begin
         p = rand_point(i == 0, given, max_ring, $urandom_range(0, 9) == 0);
         if ($urandom_range(0, 19) == 0) p.given = ~given;   // broken frame
         enqueue_point(p);
      end
   endtask

   initial begin
      point_type p;
      cfg_rings = 8'd32; cfg_keep = 8'd1; cfg_scale = 16'd256; cfg_minr = 16'd4000;
      foreach (seen_q[i]) begin
         seen_q[i] = 0; first_yaw_q[i] = 0; last_time_q[i] = 0;
      end
      phase_q = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, origin, near, ring beyond range, given and derived times.
      p = '{19'sd0, 19'sd0, 19'sd0, 8'd0, 7'd0, 20'd0, 1'b1, 1'b1};
      enqueue_point(p);                                       // origin, dropped by range
      p = '{19'h3FFFF, 19'h3FFFF, 19'h3FFFF, 8'hFF, 7'd5, 20'hFFFFF, 1'b1, 1'b0};
      enqueue_point(p);                                       // max given time
      p = '{19'h40000, 19'h40000, 19'h40000, 8'h00, 7'd127, 20'd1, 1'b1, 1'b0};
      enqueue_point(p);                                       // ring beyond max
      p = '{19'sd5000, 19'sd0, 19'sd0, 8'd1, 7'd3, 20'd7, 1'b0, 1'b1};
      enqueue_point(p);                                       // first of ring 3
      p = '{19'sd0, 19'sd5000, 19'sd0, 8'd2, 7'd3, 20'd7, 1'b0, 1'b0};
      enqueue_point(p);                                       // yaw ahead: wrap
      p = '{-19'sd5000, 19'sd0, 19'sd0, 8'd3, 7'd3, 20'd7, 1'b0, 1'b0};
      enqueue_point(p);                                       // x<0, y=0
      p = '{-19'sd5000, -19'sd1, 19'sd0, 8'd4, 7'd3, 20'd7, 1'b0, 1'b0};
      enqueue_point(p);                                       // x<0, y<0
      p = '{19'sd5000, -19'sd3000, 19'sd0, 8'd5, 7'd3, 20'd7, 1'b0, 1'b0};
      enqueue_point(p);                                       // backwards time
      p = '{19'sd0, 19'sd0, 19'sd0, 8'd6, 7'd31, 20'd7, 1'b0, 1'b0};
      enqueue_point(p);                                       // origin, ring 31
      p = '{19'sd3999, 19'sd0, 19'sd0, 8'd7, 7'd4, 20'd7, 1'b0, 1'b0};
      enqueue_point(p);                                       // just inside min range
      p = '{19'sd4000, 19'sd0, 19'sd0, 8'd8, 7'd4, 20'd7, 1'b0, 1'b0};
      enqueue_point(p);                                       // on min range
      drain_all();

      // Extremes of the registers, including zero ring count and zero keep_every.
      write_reg(slpt_pkg::CSR_RING_COUNT, 16'd0);
      write_reg(slpt_pkg::CSR_KEEP_EVERY, 16'd0);
      write_reg(slpt_pkg::CSR_TIME_SCALE, 16'hFFFF);
      write_reg(slpt_pkg::CSR_MIN_RANGE, 16'd0);
      push_frame(10, 1'b1, 127);
      drain_all();
      write_reg(slpt_pkg::CSR_RING_COUNT, 16'd128);
      write_reg(slpt_pkg::CSR_MIN_RANGE, 16'hFFFF);
      push_frame(10, 1'b1, 127);
      push_frame(10, 1'b0, 40);
      drain_all();
      write_reg(slpt_pkg::CSR_MIN_RANGE, 16'd0);
      push_frame(15, 1'b1, 127);
      push_frame(15, 1'b0, 127);
      drain_all();

      // Random phases across several settings.
      for (int ph = 0; ph < 8; ph++) begin
         write_reg(slpt_pkg::CSR_RING_COUNT, 16'($urandom_range(1, 128)));
         write_reg(slpt_pkg::CSR_KEEP_EVERY,
                   (ph == 3) ? 16'd255 : 16'($urandom_range(1, 4)));
         write_reg(slpt_pkg::CSR_TIME_SCALE, 16'($urandom));
         write_reg(slpt_pkg::CSR_MIN_RANGE, 16'($urandom_range(0, 8000)));
         if (ph == 7) idle_off = 1;
         for (int f = 0; f < 8; f++)
            push_frame($urandom_range(10, 50), $urandom_range(0, 2) == 0,
                       $urandom_range(0, 3) == 0 ? 127 : 34);
         if (ph == 2) begin
            // Long receiver hold-off while the sender keeps offering points.
            hold_rsp = 1;
            repeat (400) @(posedge clock);
            hold_rsp = 0;
         end
         if (ph == 5) begin
            // Sender pause until every kept point has come out.
            wait (pending_points.size() < 100);
            drain_req = 1;
            while (req_tvalid || expected_points.size() > 0) @(posedge clock);
            drain_req = 0;
         end
         drain_all();
      end

      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule
`default_nettype wire

>>> filelist.f
rtl/slpt_pkg.sv
rtl/slpt_front.sv
rtl/slpt_back.sv
rtl/spinning_lidar_point_timestamper.sv
tb/tb_top.sv
